// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character classifier of the base64 decoder.
package b64d_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	typedef enum logic [1:0] {
		CLS_DATA = 2'd0,
		CLS_PAD  = 2'd1,
		CLS_BAD  = 2'd2
	} b64d_class_t;

	typedef struct packed {
		b64d_class_t cls;
		logic [5:0]  sextet;
		logic        last;
	} b64d_entry_t;

	function automatic b64d_entry_t classify(input logic [7:0] c, input logic last);
		b64d_entry_t e;
		e.last   = last;
		e.sextet = 6'd0;
		e.cls    = CLS_BAD;
		if (c >= 8'h41 && c <= 8'h5A) begin
			e.cls    = CLS_DATA;
			e.sextet = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			e.cls    = CLS_DATA;
			e.sextet = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			e.cls    = CLS_DATA;
			e.sextet = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			e.cls    = CLS_DATA;
			e.sextet = 6'd62;
		end else if (c == 8'h2F) begin
			e.cls    = CLS_DATA;
			e.sextet = 6'd63;
		end else if (c == CHAR_PAD) begin
			e.cls    = CLS_PAD;
		end
		return e;
	endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// Front end: accepts characters, classifies them and pushes them into the queue.
module b64d_front (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] code_char
	input  logic                  s_tlast,   // is_last
	input  logic                  q_full,
	output logic                  q_push,
	output b64d_pkg::b64d_entry_t q_wr_entry
);

	assign s_tready   = !q_full;
	assign q_push     = s_tvalid && !q_full;
	assign q_wr_entry = b64d_pkg::classify(s_tdata, s_tlast);

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// Short queue of classified characters between front and back ends.
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64d_pkg::b64d_entry_t wr_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  rd_valid,
	output b64d_pkg::b64d_entry_t rd_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_pkg::b64d_entry_t slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back end: quad state, byte assembly, error tracking and the output register.
module b64d_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  b64d_pkg::b64d_entry_t q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] data_byte
	output logic [1:0]            m_tuser,   // [0] byte_valid, [1] bad_input
	output logic                  m_tlast    // end_of_string
);

	logic [1:0] pos_q;
	logic [5:0] left_q;
	logic [1:0] pad_q;
	logic       err_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_bv_q;
	logic       out_bad_q;
	logic       out_last_q;

	logic [5:0] left_n;
	logic [1:0] pad_n;
	logic       err_n;
	logic [7:0] byte_n;
	logic       have_byte;
	logic       bad_n;
	logic       has_result;

	assign q_pop = q_valid && (!out_valid_q || m_tready);

	always_comb begin
		left_n    = left_q;
		pad_n     = pad_q;
		err_n     = err_q;
		byte_n    = 8'd0;
		have_byte = 1'b0;
		unique case (q_entry.cls)
			b64d_pkg::CLS_PAD: begin
				if (pos_q < 2'd2) begin
					err_n = 1'b1;
				end else if (pad_q != 2'd3) begin
					pad_n = pad_q + 2'd1;
				end
				left_n = 6'd0;
			end
			b64d_pkg::CLS_DATA: begin
				if (pad_q != 2'd0) begin
					err_n  = 1'b1;
					left_n = 6'd0;
				end else begin
					unique case (pos_q)
						2'd0: begin
							left_n = q_entry.sextet;
						end
						2'd1: begin
							byte_n    = {left_q, q_entry.sextet[5:4]};
							left_n    = {2'b00, q_entry.sextet[3:0]};
							have_byte = 1'b1;
						end
						2'd2: begin
							byte_n    = {left_q[3:0], q_entry.sextet[5:2]};
							left_n    = {4'b0000, q_entry.sextet[1:0]};
							have_byte = 1'b1;
						end
						default: begin
							byte_n    = {left_q[1:0], q_entry.sextet};
							left_n    = 6'd0;
							have_byte = 1'b1;
						end
					endcase
				end
			end
			default: begin
				err_n  = 1'b1;
				left_n = 6'd0;
			end
		endcase
		bad_n      = err_n || (q_entry.last && pos_q != 2'd3);
		has_result = have_byte || q_entry.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			left_q <= 6'd0;
			pad_q  <= 2'd0;
			err_q  <= 1'b0;
		end else if (q_pop) begin
			if (q_entry.last) begin
				pos_q  <= 2'd0;
				left_q <= 6'd0;
				pad_q  <= 2'd0;
				err_q  <= 1'b0;
			end else begin
				pos_q  <= pos_q + 2'd1;
				left_q <= left_n;
				pad_q  <= pad_n;
				err_q  <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_result) begin
			out_byte_q <= byte_n;
			out_bv_q   <= have_byte;
			out_bad_q  <= bad_n;
			out_last_q <= q_entry.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_bad_q, out_bv_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder.
// Decodes one base64 character (standard alphabet, '=' padding) per request; a byte
// comes out on the second, third and fourth character of each quad, and the request
// marked tlast always yields a result carrying the final bad_input verdict for the
// string. The front end classifies and queues a character in the cycle it is
// accepted, whenever the queue is not full; the back end retires one queued
// character per cycle while the output register is empty or being read. Each
// character passes through a queue slot and its result through a single output
// register; up to DEPTH characters are buffered while the output is stalled.
module base64_stream_decoder #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] code_char
	input  logic       s_tlast,   // is_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [0] byte_valid, [1] bad_input
	output logic       m_tlast    // end_of_string
);

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	b64d_pkg::b64d_entry_t q_wr_entry;
	b64d_pkg::b64d_entry_t q_rd_entry;

	b64d_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wr_entry (q_wr_entry)
	);

	b64d_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_rd_entry)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the base64 decoder: directed, random and drain-pause strings.
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [7:0] data;
		logic       byte_ok;
		logic       eos;
		logic       bad;
	} dec_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] code_char
	logic       s_tlast = 1'b0;    // is_last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] data_byte
	logic [1:0] m_tuser;           // [0] byte_valid, [1] bad_input
	logic       m_tlast;           // end_of_string

	// predictor state
	logic [1:0] quad_pos = '0;
	logic [5:0] carry_bits = '0;
	logic [1:0] pad_seen = '0;
	logic       string_bad = 1'b0;

	dec_result_t pending_results[$];
	logic [7:0]  text[$];
	string       alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	int          mismatches = 0;
	int          results_seen = 0;
	int          chars_sent = 0;
	int          idle_cycles = 0;
	int          ready_hold = 0;
	bit          quiet = 1'b0;

	base64_stream_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at result %0d: %s got %02h expected %02h",
				results_seen, what, got, want);
		mismatches++;
	endtask

	// works out the result, if any, of one accepted character
	task automatic decode_char(input logic [7:0] c, input logic last);
		b64d_pkg::b64d_class_t kind;
		logic [5:0]  sx;
		logic [1:0]  pos;
		logic        got;
		dec_result_t r;
		kind = b64d_pkg::CLS_BAD;
		sx   = '0;
		got  = 1'b0;
		r    = '0;
		pos  = quad_pos;
		if (c >= "A" && c <= "Z") begin
			kind = b64d_pkg::CLS_DATA;
			sx   = 6'(c - "A");
		end else if (c >= "a" && c <= "z") begin
			kind = b64d_pkg::CLS_DATA;
			sx   = 6'(c - "a" + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			kind = b64d_pkg::CLS_DATA;
			sx   = 6'(c - "0" + 8'd52);
		end else if (c == "+") begin
			kind = b64d_pkg::CLS_DATA;
			sx   = 6'd62;
		end else if (c == "/") begin
			kind = b64d_pkg::CLS_DATA;
			sx   = 6'd63;
		end else if (c == b64d_pkg::CHAR_PAD) begin
			kind = b64d_pkg::CLS_PAD;
		end
		case (kind)
			b64d_pkg::CLS_BAD: begin
				string_bad = 1'b1;
				carry_bits = '0;
			end
			b64d_pkg::CLS_PAD: begin
				if (pos < 2'd2)
					string_bad = 1'b1;
				else if (pad_seen != 2'd3)
					pad_seen = pad_seen + 2'd1;
				carry_bits = '0;
			end
			default: begin
				if (pad_seen != 2'd0) begin
					string_bad = 1'b1;
					carry_bits = '0;
				end else begin
					case (pos)
						2'd0: carry_bits = sx;
						2'd1: begin
							r.data     = {carry_bits, sx[5:4]};
							carry_bits = {2'b00, sx[3:0]};
							got        = 1'b1;
						end
						2'd2: begin
							r.data     = {carry_bits[3:0], sx[5:2]};
							carry_bits = {4'b0000, sx[1:0]};
							got        = 1'b1;
						end
						default: begin
							r.data     = {carry_bits[1:0], sx};
							carry_bits = '0;
							got        = 1'b1;
						end
					endcase
				end
			end
		endcase
		r.bad    = string_bad | (last && pos != 2'd3);
		quad_pos = pos + 2'd1;
		if (got || last) begin
			r.byte_ok = got;
			r.eos     = last;
			pending_results.push_back(r);
		end
		if (last) begin
			quad_pos   = '0;
			carry_bits = '0;
			pad_seen   = '0;
			string_bad = 1'b0;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_char(c, last);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic build_valid();
		int quads;
		int pads;
		text.delete();
		quads = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
		pads  = $urandom_range(0, 2);
		repeat (4 * quads)
			text.push_back(alphabet[$urandom_range(0, 63)]);
		if (pads >= 1)
			text[text.size() - 1] = b64d_pkg::CHAR_PAD;
		if (pads == 2)
			text[text.size() - 2] = b64d_pkg::CHAR_PAD;
	endtask

	task automatic break_text();
		case ($urandom_range(0, 3))
			0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
			1: if (text.size() > 1) void'(text.pop_back());
			2: text[$urandom_range(0, text.size() - 1)] = b64d_pkg::CHAR_PAD;
			default: text.push_back(alphabet[$urandom_range(0, 63)]);
		endcase
	endtask

	task automatic build_noise();
		text.delete();
		repeat ($urandom_range(1, 8))
			text.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		// sextet extremes: bytes 00 0F FF
		text = '{"A", "A", "/", "/"};
		send_text();
		// lower case, plus, digit, one pad
		text = '{"z", "+", "9", b64d_pkg::CHAR_PAD};
		send_text();
		// bad character first, then a byte built on cleared bits, two pads
		text = '{8'h00, "A", b64d_pkg::CHAR_PAD, b64d_pkg::CHAR_PAD};
		send_text();
		// pad in the wrong place, top code value
		text = '{b64d_pkg::CHAR_PAD, "Z", 8'hFF, "a"};
		send_text();
		// data after padding
		text = '{"T", "Q", b64d_pkg::CHAR_PAD, "g"};
		send_text();
		// length not a multiple of four
		text = '{"T", "W", "F"};
		send_text();
		// single character just above the alphabet
		text = '{8'h7B};
		send_text();
	endtask

	task automatic test_random_strings(input int target);
		int start;
		int kind;
		start = chars_sent;
		while (chars_sent - start < target) begin
			kind = $urandom_range(0, 9);
			build_valid();
			if (kind == 7 || kind == 8)
				break_text();
			else if (kind == 9)
				build_noise();
			send_text();
		end
	endtask

	task automatic test_back_to_back(input int target);
		quiet = 1'b1;
		test_random_strings(target);
		quiet = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			build_valid();
			send_text();
			wait_results_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_strings(450);
		test_drain_pause();
		test_back_to_back(150);
		test_random_strings(450);
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[base64_stream_decoder] OK");
		else
			$display("[base64_stream_decoder] ERROR");
		$finish;
	end

	// output side stalls
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold = ready_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, data", m_tdata, 8'h00);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.data)
					report_mismatch("data_byte", m_tdata, want.data);
				if (m_tuser[0] !== want.byte_ok)
					report_mismatch("byte_valid", 8'(m_tuser[0]), 8'(want.byte_ok));
				if (m_tuser[1] !== want.bad)
					report_mismatch("bad_input", 8'(m_tuser[1]), 8'(want.bad));
				if (m_tlast !== want.eos)
					report_mismatch("end_of_string", 8'(m_tlast), 8'(want.eos));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[base64_stream_decoder] ERROR");
			$finish;
		end
	end

endmodule

// ===== base64_stream_decoder.f =====
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
verif/testbench.sv
